/* sv/ssbp_pkg.sv */
package ssbp_pkg;

  // payload widths fixed by the item format
  localparam int DUR_W  = 12;
  localparam int PART_W = 12;

  // extra quotient bits for the reciprocal multiply (word size is at most 2**7)
  localparam int RECIP_XTRA = 7;

  typedef logic [DUR_W-1:0]  duration_t;
  typedef logic [PART_W-1:0] part_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_QUOT,
    ST_REM,
    ST_SWEEP,
    ST_DRAIN_C,
    ST_DRAIN_S,
    ST_FINISH
  } state_t;

endpackage

/* sv/ssbp_if.sv */
interface ssbp_in_if;
  logic                valid;
  logic                ready;
  ssbp_pkg::duration_t duration;
  logic                last;

  modport source (output valid, output duration, output last, input ready);
  modport sink   (input valid, input duration, input last, output ready);
endinterface

interface ssbp_out_if;
  logic            valid;
  logic            ready;
  ssbp_pkg::part_t larger_part;
  logic            overflow;

  modport source (output valid, output larger_part, output overflow, input ready);
  modport sink   (input valid, input larger_part, input overflow, output ready);
endinterface

/* sv/subset_sum_balanced_partition.sv */
// channel  dir  payload                   meaning
// item     in   duration[11:0], last      one duration of the set, last closes the set
// result   out  larger_part[11:0], overflow  larger half of the best split, total overflow
//
// each item passes the setup states ST_QUOT and ST_REM, which split the duration into a
// word shift and a bit shift, then one pass walks every bitset word of the memory from the
// top down, two reads and one write per cycle, then the drain states ST_DRAIN_C and ST_DRAIN_S
// rst is synchronous; right after it the store reads as "only sum zero reachable" with no
// clearing pass, because the first item of every set rewrites all words
// a finished result waits in the output register; only a last item that finds the register
// still full holds in its final cycle until the result transfer takes place
module subset_sum_balanced_partition #(
  parameter int MAX_TOTAL = 4095,
  parameter int WORD_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  ssbp_in_if.sink     item,
  ssbp_out_if.source  result
);

  localparam int DUR_W    = ssbp_pkg::DUR_W;
  localparam int PART_W   = ssbp_pkg::PART_W;
  localparam int HALF_MAX = MAX_TOTAL / 2;
  localparam int NWORDS   = HALF_MAX / WORD_BITS + 1;
  localparam int TW       = $clog2(MAX_TOTAL + 1);
  localparam int SUMW     = ((TW > DUR_W) ? TW : DUR_W) + 1;
  localparam int AW       = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int CW       = $clog2(NWORDS + 1);
  localparam int PW       = ((CW > DUR_W) ? CW : DUR_W) + 2;
  localparam int BASEW    = $clog2(NWORDS * WORD_BITS + 1);
  localparam int LW       = ((TW > BASEW) ? TW : BASEW) + 2;
  localparam int RW       = $clog2(WORD_BITS);
  localparam int KSH      = DUR_W + ssbp_pkg::RECIP_XTRA;
  localparam int RECIP    = ((1 << KSH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RECW     = $clog2(RECIP + 1);
  localparam int PRODW    = DUR_W + RECW;

  // fsm
  ssbp_pkg::state_t state, state_next;
  logic out_load;

  // per-set state
  logic [TW-1:0] total;
  logic          ovf;
  logic          fresh;   // store content is stale, reads as the reset pattern

  // per-item registers
  ssbp_pkg::duration_t d_reg;
  logic                last_reg;
  logic                en;       // duration adds reachable sums
  logic [DUR_W-1:0]    q_reg;    // word shift
  logic [RW-1:0]       r_reg;    // bit shift within a word

  // sweep counters
  logic [CW-1:0]        wcnt;
  logic signed [PW-1:0] b_ptr;
  logic [BASEW-1:0]     base_cnt;

  // memory and read data
  logic [WORD_BITS-1:0] mem [NWORDS];
  logic [WORD_BITS-1:0] rdata_a, rdata_b;
  logic [AW-1:0]        a_addr, b_addr;

  // compute stage
  logic                 c_act, c_valid, c_own_zero, c_b_ok, c_b_zero;
  logic [AW-1:0]        c_word;
  logic [BASEW-1:0]     c_base;
  logic [WORD_BITS-1:0] src_hi, src_lo, own, shifted, new_word;
  logic [RW:0]          rshift;

  // search stage
  logic                 s_valid;
  logic [WORD_BITS-1:0] s_word;
  logic [BASEW-1:0]     s_base;
  logic                 found;
  logic [TW-1:0]        best, half;
  logic [WORD_BITS-1:0] masked;
  logic [RW-1:0]        msb_idx;
  logic signed [LW-1:0] lim;

  // result register
  logic              res_valid;
  ssbp_pkg::part_t   res_part;
  logic              res_ovf;

  logic [SUMW-1:0]  sum;
  logic [PRODW-1:0] prod;
  logic [DUR_W-1:0] qw;

  assign result.valid       = res_valid;
  assign result.larger_part = res_part;
  assign result.overflow    = res_ovf;

  // ---------------------------------------------------------------- fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssbp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ssbp_pkg::ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          state_next = ssbp_pkg::ST_QUOT;
        end
      end
      ssbp_pkg::ST_QUOT:    state_next = ssbp_pkg::ST_REM;
      ssbp_pkg::ST_REM:     state_next = ssbp_pkg::ST_SWEEP;
      ssbp_pkg::ST_SWEEP: begin
        if (wcnt == '0) begin
          state_next = ssbp_pkg::ST_DRAIN_C;
        end
      end
      ssbp_pkg::ST_DRAIN_C: state_next = ssbp_pkg::ST_DRAIN_S;
      ssbp_pkg::ST_DRAIN_S: state_next = ssbp_pkg::ST_FINISH;
      ssbp_pkg::ST_FINISH: begin
        if (!last_reg) begin
          state_next = ssbp_pkg::ST_IDLE;
        end else if (!res_valid || result.ready) begin
          out_load   = 1'b1;
          state_next = ssbp_pkg::ST_IDLE;
        end
      end
      default: state_next = ssbp_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- item intake, shift split
  assign sum  = SUMW'(total) + SUMW'(item.duration);
  // quotient by the word size through a reciprocal multiply, exact for 12-bit durations
  assign prod = PRODW'(d_reg) * PRODW'(RECIP);
  assign qw   = DUR_W'(prod >> KSH);

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      ovf      <= 1'b0;
      fresh    <= 1'b1;
      last_reg <= 1'b0;
    end else begin
      if (item.valid && item.ready) begin
        d_reg    <= item.duration;
        last_reg <= item.last;
        en       <= (item.duration != '0) && (SUMW'(item.duration) <= SUMW'(HALF_MAX));
        if (sum > SUMW'(MAX_TOTAL)) begin
          total <= TW'(MAX_TOTAL);
          ovf   <= 1'b1;
        end else begin
          total <= TW'(sum);
        end
      end
      if (state == ssbp_pkg::ST_FINISH && !last_reg) begin
        fresh <= 1'b0;
      end
      if (out_load) begin
        total <= '0;
        ovf   <= 1'b0;
        fresh <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ssbp_pkg::ST_QUOT) begin
      q_reg <= en ? qw : '0;
    end
    if (state == ssbp_pkg::ST_REM) begin
      r_reg    <= RW'(d_reg - DUR_W'(q_reg * DUR_W'(WORD_BITS)));
      b_ptr    <= PW'(NWORDS - 1) - PW'(q_reg);
      wcnt     <= CW'(NWORDS);
      base_cnt <= BASEW'(NWORDS * WORD_BITS);
    end else if (state == ssbp_pkg::ST_SWEEP) begin
      b_ptr    <= b_ptr - PW'(1);
      wcnt     <= wcnt - CW'(1);
      base_cnt <= base_cnt - BASEW'(WORD_BITS);
    end
  end

  // ---------------------------------------------------------------- memory, two reads one write
  // own word wcnt and source word b_ptr; the source word one above is kept in src_hi
  assign a_addr = wcnt[AW-1:0];
  assign b_addr = b_ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (state == ssbp_pkg::ST_SWEEP) begin
      rdata_a <= mem[a_addr];
      rdata_b <= mem[b_addr];
    end
    if (c_valid) begin
      mem[c_word] <= new_word;
    end
  end

  // ---------------------------------------------------------------- compute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      c_act   <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      c_act   <= (state == ssbp_pkg::ST_SWEEP);
      c_valid <= (state == ssbp_pkg::ST_SWEEP) && (wcnt != CW'(NWORDS));
    end
    c_word     <= a_addr;
    c_own_zero <= (wcnt == '0);
    c_b_ok     <= !b_ptr[PW-1];
    c_b_zero   <= (b_ptr == '0);
    c_base     <= base_cnt;
    if (c_act) begin
      src_hi <= src_lo;
    end
  end

  // stale words read as the reset pattern: sum zero only
  always_comb begin
    own    = fresh ? WORD_BITS'(c_own_zero) : rdata_a;
    src_lo = '0;
    if (c_b_ok) begin
      src_lo = fresh ? WORD_BITS'(c_b_zero) : rdata_b;
    end
    rshift  = (RW+1)'(WORD_BITS) - (RW+1)'(r_reg);
    shifted = src_hi << r_reg;
    if (r_reg != '0) begin
      shifted = shifted | (src_lo >> rshift);
    end
    new_word = own | (en ? shifted : '0);
  end

  // ---------------------------------------------------------------- search stage
  // words come top down, so the first word with a hit holds the best sum
  assign half = total >> 1;

  always_comb begin
    lim     = LW'(half) - LW'(s_base);
    masked  = '0;
    msb_idx = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      masked[b] = s_word[b] && (LW'(b) <= lim) && !(s_base == '0 && b == 0);
    end
    for (int b = 0; b < WORD_BITS; b++) begin
      if (masked[b]) begin
        msb_idx = RW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
      found   <= 1'b0;
    end else begin
      s_valid <= c_valid;
      if (state == ssbp_pkg::ST_REM) begin
        found <= 1'b0;
      end else if (s_valid && last_reg && !found && masked != '0) begin
        found <= 1'b1;
      end
    end
    s_word <= new_word;
    s_base <= c_base;
    if (state == ssbp_pkg::ST_REM) begin
      best <= '0;
    end else if (s_valid && last_reg && !found && masked != '0) begin
      best <= TW'(s_base + BASEW'(msb_idx));
    end
  end

  // ---------------------------------------------------------------- result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_load) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (out_load) begin
      res_part <= ovf ? '0 : PART_W'(total - best);
      res_ovf  <= ovf;
    end
  end

  // ---------------------------------------------------------------- checks
  a_fresh_after_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> fresh)
    else $error("store not marked stale after a result");

  a_best_in_range: assert property (@(posedge clk) disable iff (rst)
    found && (state == ssbp_pkg::ST_FINISH) |-> (best <= half) && (best != '0))
    else $error("best sum outside one to half the total");

  a_found_from_search: assert property (@(posedge clk) disable iff (rst)
    $rose(found) |-> $past(s_valid) && $past(last_reg))
    else $error("best sum set outside the search stage");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    c_valid |-> ($past(wcnt) < CW'(NWORDS)))
    else $error("bitset write beyond the last word");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready |=> res_valid && $stable(res_part) && $stable(res_ovf))
    else $error("waiting result lost or overwritten");

endmodule

/* dv/ssbp_split_checker.sv */
module ssbp_split_checker #(
  parameter int MAX_TOTAL = 4095
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  input  logic                item_ready,
  input  ssbp_pkg::duration_t item_duration,
  input  logic                item_last,
  input  logic                result_valid,
  input  logic                result_ready,
  input  ssbp_pkg::part_t     result_larger_part,
  input  logic                result_overflow,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HALF_MAX = MAX_TOTAL / 2;

  typedef struct packed {
    ssbp_pkg::part_t larger_part;
    logic            overflow;
  } split_t;

  // sums reachable by some subset of the current set, 0..HALF_MAX
  bit [HALF_MAX:0] reach_sums;
  int unsigned     set_total;
  bit              set_overflowed;
  split_t          expected_splits[$];

  task automatic clear_set();
    reach_sums     = '0;
    reach_sums[0]  = 1'b1;
    set_total      = 0;
    set_overflowed = 1'b0;
  endtask

  task automatic absorb_duration(input ssbp_pkg::duration_t d, input logic is_last);
    int unsigned half;
    int unsigned best;
    split_t      split;
    if (set_total + d > MAX_TOTAL) begin
      set_total      = MAX_TOTAL;
      set_overflowed = 1'b1;
    end else begin
      set_total = set_total + d;
    end
    // durations above half the bound add no sums, the shift drops the top
    if (d != 0 && d <= HALF_MAX) begin
      reach_sums = reach_sums | (reach_sums << d);
    end
    if (is_last) begin
      if (set_overflowed) begin
        split.larger_part = '0;
        split.overflow    = 1'b1;
      end else begin
        half = set_total / 2;
        best = 0;
        for (int unsigned j = half; j >= 1 && best == 0; j--) begin
          if (reach_sums[j]) begin
            best = j;
          end
        end
        split.larger_part = ssbp_pkg::part_t'(set_total - best);
        split.overflow    = 1'b0;
      end
      expected_splits.push_back(split);
      clear_set();
    end
  endtask

  always @(posedge clk) begin
    split_t want;
    if (rst) begin
      clear_set();
      expected_splits.delete();
      fail_count = 0;
    end else begin
      if (item_valid && item_ready) begin
        absorb_duration(item_duration, item_last);
      end
      if (result_valid && result_ready) begin
        if (expected_splits.size() == 0) begin
          fail_count++;
          $error("unexpected result: larger_part %0d overflow %0b",
                 result_larger_part, result_overflow);
        end else begin
          want = expected_splits.pop_front();
          if (result_larger_part !== want.larger_part) begin
            fail_count++;
            $error("larger_part mismatch: expected %0d, actual %0d",
                   want.larger_part, result_larger_part);
          end
          if (result_overflow !== want.overflow) begin
            fail_count++;
            $error("overflow mismatch: expected %0b, actual %0b",
                   want.overflow, result_overflow);
          end
        end
      end
    end
    pending = expected_splits.size();
  end

endmodule

/* dv/subset_sum_balanced_partition_test.sv */
module subset_sum_balanced_partition_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_TOTAL   = 4095;
  localparam int PHASE_ITEMS = 345;     // random durations per idling mix
  localparam int LONG_HOLD   = 600;     // cycles of result back-pressure
  localparam int TAIL_CYCLES = 100;     // idle cycles after the last result
  localparam int CYCLE_LIMIT = 600_000;

  logic clk;
  logic rst;

  ssbp_in_if  item_ch ();
  ssbp_out_if result_ch ();

  int fail_count;
  int pending;

  // idling knobs, percent per cycle
  int send_idle_pct;
  int recv_stall_pct;

  // long receiver hold, requested here and timed by the receiver process
  bit hold_req;
  bit hold_done;

  // run statistics for the summary
  int          items_sent;
  int          sets_sent;
  int          overflow_sets;
  int unsigned stim_total;
  int          cycle_count = 0;

  subset_sum_balanced_partition u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch)
  );

  ssbp_split_checker #(.MAX_TOTAL(MAX_TOTAL)) u_split_checker (
    .clk                (clk),
    .rst                (rst),
    .item_valid         (item_ch.valid),
    .item_ready         (item_ch.ready),
    .item_duration      (item_ch.duration),
    .item_last          (item_ch.last),
    .result_valid       (result_ch.valid),
    .result_ready       (result_ch.ready),
    .result_larger_part (result_ch.larger_part),
    .result_overflow    (result_ch.overflow),
    .fail_count         (fail_count),
    .pending            (pending)
  );

  // 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold when asked
  initial begin
    result_ch.ready = 1'b0;
    hold_done       = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
      end
      result_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      @(negedge clk);
    end
  end

  // one duration transfer; entered and left at a falling edge, left with valid still up,
  // so the caller either sends again or drains right away
  task automatic send_item(input ssbp_pkg::duration_t d, input logic is_last);
    int gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      // mostly short gaps, now and then one long enough to land on any sweep phase
      if ($urandom_range(0, 15) == 0) begin
        gap = $urandom_range(1, 45);
      end else begin
        while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
      end
    end
    if (gap != 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_ch.valid    <= 1'b1;
    item_ch.duration <= d;
    item_ch.last     <= is_last;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
    stim_total += d;
    if (is_last) begin
      sets_sent++;
      if (stim_total > MAX_TOTAL) overflow_sets++;
      stim_total = 0;
    end
  endtask

  // sender pause until every expected split has come back
  task automatic drain_results();
    item_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // one set of random shape; most sets stay under the total bound
  task automatic send_random_set();
    int                  len;
    int                  top_val;
    int                  pick;
    ssbp_pkg::duration_t d;
    ssbp_pkg::duration_t corner[8];
    corner = '{12'd0, 12'd1, 12'd2, 12'd2046, 12'd2047, 12'd2048, 12'd4094, 12'd4095};
    pick = $urandom_range(0, 9);
    if (pick <= 4) begin
      // short sets of small durations, split lands close to half
      len     = $urandom_range(1, 8);
      top_val = $urandom_range(1, 255);
    end else if (pick <= 6) begin
      len     = $urandom_range(1, 6);
      top_val = 1023;
    end else if (pick == 7) begin
      // full range, overflow likely past two items
      len     = $urandom_range(1, 4);
      top_val = 4095;
    end else if (pick == 8) begin
      // long sets of tiny durations fill the low words of the bitset
      len     = $urandom_range(20, 40);
      top_val = 63;
    end else begin
      len     = $urandom_range(1, 3);
      top_val = 0;
    end
    for (int k = 0; k < len; k++) begin
      if (pick == 9) d = corner[$urandom_range(0, 7)];
      else           d = ssbp_pkg::duration_t'($urandom_range(0, top_val));
      send_item(d, k == len - 1);
    end
  endtask

  initial begin
    int phase_start;
    rst              = 1'b1;
    item_ch.valid    = 1'b0;
    item_ch.duration = '0;
    item_ch.last     = 1'b0;
    hold_req         = 1'b0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    items_sent       = 0;
    sets_sent        = 0;
    overflow_sets    = 0;
    stim_total       = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: lone zero, lone one, lone maximum (no sums above half)
    send_item(12'd0, 1'b1);
    send_item(12'd1, 1'b1);
    send_item(12'd4095, 1'b1);
    // exact half next to one above half, total right at the bound
    send_item(12'd2047, 1'b0);
    send_item(12'd2048, 1'b1);
    // overflow in one step, then by accumulation
    send_item(12'd4095, 1'b0);
    send_item(12'd1, 1'b1);
    send_item(12'd3000, 1'b0);
    send_item(12'd2000, 1'b0);
    send_item(12'd5, 1'b1);
    // zero durations leave the sums alone
    send_item(12'd0, 1'b0);
    send_item(12'd0, 1'b0);
    send_item(12'd5, 1'b1);
    // even split of equal durations
    send_item(12'd1, 1'b0);
    send_item(12'd1, 1'b0);
    send_item(12'd1, 1'b0);
    send_item(12'd1, 1'b1);
    // alternating bit patterns
    send_item(12'hAAA, 1'b0);
    send_item(12'h555, 1'b1);
    // no subset reaches half exactly
    send_item(12'd3, 1'b0);
    send_item(12'd5, 1'b0);
    send_item(12'd7, 1'b1);
    drain_results();

    // result side held off while sets keep coming, input must back up
    hold_req = 1'b1;
    for (int s = 0; s < 12; s++) begin
      send_item(ssbp_pkg::duration_t'($urandom_range(0, 300)), 1'b0);
      send_item(ssbp_pkg::duration_t'($urandom_range(0, 300)), 1'b1);
    end
    drain_results();

    // random sets under each idling mix, fully drained in between
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 68;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 68;
        end
        default: begin
          send_idle_pct  = 30;
          recv_stall_pct = 30;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) send_random_set();
      drain_results();
    end

    // let any stray result show up before the verdict
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d durations in %0d sets, %0d sets past the total bound",
             items_sent, sets_sent, overflow_sets);
    $display("idling: none, sender 68%%, receiver 68%%, both 30%%, one %0d-cycle result hold",
             LONG_HOLD);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/ssbp_pkg.sv
sv/ssbp_if.sv
sv/subset_sum_balanced_partition.sv
dv/ssbp_split_checker.sv
dv/subset_sum_balanced_partition_test.sv
